### hdl/nrta_pkg.sv
// ----------------------------------------------------------------------------
// nrta_pkg
// Shared types and constants for the NAPOT region table allocator: request
// and result codes, attribute type field codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package nrta_pkg;

    // Fixed field widths
    localparam int SIZE_BITS = 41;
    localparam int FLAGS_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNSUP    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERLAP  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FAIL     = 2'd3;

    // Attribute type field (bits 1:0 of the flag byte)
    localparam logic [FLAGS_W-1:0] ETYP_MASK  = 8'h03;
    localparam logic [FLAGS_W-1:0] ETYP_OFF   = 8'h00;
    localparam logic [FLAGS_W-1:0] ETYP_NAPOT = 8'h03;

    // Register index (paddr[2]) of the support flag
    localparam logic REG_IDX_PMA = 1'b0;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FINISH
    } nrta_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // capture the request
        logic prep;     // derive end, checks, encoded word; clear scan flags
        logic scan;     // read one table entry into the scan pipe
        logic commit;   // update table, load result register
    } nrta_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;     // scan counter at the final entry
        logic out_free; // result register can take a new result
    } nrta_sts_t;

endpackage

`default_nettype wire

### hdl/napot_region_table_alloc_unit.sv
// ----------------------------------------------------------------------------
// napot_region_table_alloc_unit
// NAPOT memory-attribute region table with allocate and free requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (valid/ready): s_mode selects allocate
//   or free, with base address, size and flag byte. Each request gives one
//   result on the m_ channel: a status code and the entry index.
//   The APB port holds one register at address 0: bit 0 is the support flag
//   (reset 1). Write it only while no request is in flight.
// Sequence:
//   m_valid rises after an accepted request has passed through the setup
//   state, a scan of every entry through the single-read table, the drain
//   states DRAIN1 and DRAIN2 for the decode/compare pipe, and the commit.
//   One request is worked at a time: a new request is accepted only once the
//   previous one has committed its result.
// Reset:
//   Synchronous, active low. All entries are disabled and the support flag
//   is set. No clearing pass is needed.
// Stall:
//   A held result stays in the output register; the next request may be
//   accepted and scanned, and its commit waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module napot_region_table_alloc_unit #(
    parameter int NUM_ENTRIES     = 16,
    parameter int ADDR_BITS       = 40,
    parameter int MIN_REGION_LOG2 = 12
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // APB configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [nrta_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [nrta_pkg::PDATA_W-1:0]       pwdata,
    output logic      [nrta_pkg::PDATA_W-1:0]       prdata,
    output logic                                    pready,
    // Request channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_mode,
    input  wire logic [ADDR_BITS-1:0]               s_base_address,
    input  wire logic [nrta_pkg::SIZE_BITS-1:0]     s_region_size,
    input  wire logic [nrta_pkg::FLAGS_W-1:0]       s_region_flags,
    // Result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [nrta_pkg::STATUS_W-1:0]           m_status,
    output logic [nrta_pkg::OUT_IDX_W-1:0]          m_entry_index
);

    logic                pma_supported_reg;
    logic                cfg_wr;
    nrta_pkg::nrta_cmd_t cmd;
    nrta_pkg::nrta_sts_t sts;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[2] == nrta_pkg::REG_IDX_PMA);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pma_supported_reg <= 1'b1;
        end else if (cfg_wr) begin
            pma_supported_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == nrta_pkg::REG_IDX_PMA)
                  ? {{(nrta_pkg::PDATA_W - 1){1'b0}}, pma_supported_reg}
                  : '0;

    // Sequencer
    nrta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table and scan datapath
    nrta_dp #(
        .NUM_ENTRIES     (NUM_ENTRIES),
        .ADDR_BITS       (ADDR_BITS),
        .MIN_REGION_LOG2 (MIN_REGION_LOG2)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .pma_supported  (pma_supported_reg),
        .s_mode         (s_mode),
        .s_base_address (s_base_address),
        .s_region_size  (s_region_size),
        .s_region_flags (s_region_flags),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_entry_index  (m_entry_index)
    );

endmodule

`default_nettype wire

### hdl/nrta_ctrl.sv
// ----------------------------------------------------------------------------
// nrta_ctrl
// Request sequencer: accepts a request, runs one pass over the table, waits
// for the scan pipe to drain, then commits once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module nrta_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire nrta_pkg::nrta_sts_t sts,
    output nrta_pkg::nrta_cmd_t      cmd
);

    nrta_pkg::nrta_state_t state_reg;
    nrta_pkg::nrta_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nrta_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            nrta_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = nrta_pkg::ST_PREP;
                end
            end
            nrta_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = nrta_pkg::ST_SCAN;
            end
            nrta_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.last) begin
                    state_next = nrta_pkg::ST_DRAIN1;
                end
            end
            nrta_pkg::ST_DRAIN1: begin
                state_next = nrta_pkg::ST_DRAIN2;
            end
            nrta_pkg::ST_DRAIN2: begin
                state_next = nrta_pkg::ST_FINISH;
            end
            nrta_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = nrta_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nrta_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/nrta_dp.sv
// ----------------------------------------------------------------------------
// nrta_dp
// Datapath: request registers, region table (enable bits plus encoded word
// memory), three-stage scan pipe (read, decode, compare), result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nrta_dp #(
    parameter int NUM_ENTRIES     = 16,
    parameter int ADDR_BITS       = 40,
    parameter int MIN_REGION_LOG2 = 12
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire nrta_pkg::nrta_cmd_t                cmd,
    output nrta_pkg::nrta_sts_t                     sts,
    input  wire logic                               pma_supported,
    input  wire logic                               s_mode,
    input  wire logic [ADDR_BITS-1:0]               s_base_address,
    input  wire logic [nrta_pkg::SIZE_BITS-1:0]     s_region_size,
    input  wire logic [nrta_pkg::FLAGS_W-1:0]       s_region_flags,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [nrta_pkg::STATUS_W-1:0]           m_status,
    output logic [nrta_pkg::OUT_IDX_W-1:0]          m_entry_index
);

    localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int WORD_W = ADDR_BITS - 2;
    localparam int SZ_W   = nrta_pkg::SIZE_BITS;
    localparam int END_W  = ADDR_BITS + 1;
    localparam int EXT_W  = ((END_W > SZ_W) ? END_W : SZ_W) + 1;
    localparam int OIDX_W = nrta_pkg::OUT_IDX_W;
    localparam int FL_W   = nrta_pkg::FLAGS_W;

    // Request registers
    logic                  mode_reg;
    logic [ADDR_BITS-1:0]  base_reg;
    logic [SZ_W-1:0]       size_reg;
    logic [SZ_W-1:0]       size_m1_reg;
    logic [FL_W-1:0]       type_reg;

    // Derived request values
    logic [EXT_W-1:0]      nend_reg;
    logic                  bad_reg;
    logic                  size_zero_reg;
    logic [WORD_W-1:0]     word_reg;

    // Table
    logic [NUM_ENTRIES-1:0] on_reg;
    logic [WORD_W-1:0]      word_mem [NUM_ENTRIES];

    // Scan pipe
    logic [IDX_W-1:0]      cnt_reg;
    logic                  a_vld_reg;
    logic [IDX_W-1:0]      a_idx_reg;
    logic                  a_on_reg;
    logic [WORD_W-1:0]     a_word_reg;
    logic                  b_vld_reg;
    logic [IDX_W-1:0]      b_idx_reg;
    logic                  b_on_reg;
    logic [ADDR_BITS-1:0]  b_start_reg;
    logic [END_W-1:0]      b_end_reg;

    // Scan results
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic                  slot_reg;
    logic [IDX_W-1:0]      slot_idx_reg;

    // Result register
    logic                  m_valid_reg;
    logic [nrta_pkg::STATUS_W-1:0] status_reg;
    logic [OIDX_W-1:0]     index_reg;

    logic [EXT_W-1:0]      nend_calc;
    logic                  bad_calc;
    logic [WORD_W:0]       w_ext;
    logic [WORD_W:0]       w_xor;
    logic [WORD_W-1:0]     low_mask;
    logic [ADDR_BITS-1:0]  dec_start;
    logic [END_W-1:0]      dec_end;
    logic                  match;
    logic                  overlap;
    logic                  entry_hit;
    logic [nrta_pkg::STATUS_W-1:0] status_calc;
    logic [IDX_W-1:0]      index_calc;

    assign sts.last     = (cnt_reg == IDX_W'(NUM_ENTRIES - 1));
    assign sts.out_free = !m_valid_reg || m_ready;

    // Request capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg    <= s_mode;
            base_reg    <= s_base_address;
            size_reg    <= s_region_size;
            size_m1_reg <= s_region_size - SZ_W'(1);
            type_reg    <= s_region_flags & nrta_pkg::ETYP_MASK;
        end
    end

    // End address, region checks and encoded word
    always_comb begin
        nend_calc = EXT_W'(base_reg) + EXT_W'(size_m1_reg);
        bad_calc  = (size_reg < (SZ_W'(1) << MIN_REGION_LOG2))
                 || (EXT_W'(size_reg) > (EXT_W'(1) << ADDR_BITS))
                 || ((size_reg & size_m1_reg) != '0)
                 || ((EXT_W'(base_reg) & EXT_W'(size_m1_reg)) != '0)
                 || (type_reg != nrta_pkg::ETYP_NAPOT);
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            nend_reg      <= nend_calc;
            bad_reg       <= bad_calc;
            size_zero_reg <= (size_reg == '0);
            // aligned power-of-two region: the add is an OR
            word_reg      <= base_reg[ADDR_BITS-1:2] | WORD_W'(size_m1_reg >> 3);
        end
    end

    // Scan counter and table read stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            if (cmd.prep) begin
                cnt_reg <= '0;
            end else if (cmd.scan && !sts.last) begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            a_vld_reg <= cmd.scan;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_idx_reg <= cnt_reg;
        a_on_reg  <= on_reg[cnt_reg];
    end

    // Encoded word memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.commit && (status_calc == nrta_pkg::STATUS_OK)
                && (mode_reg == nrta_pkg::MODE_ALLOC)) begin
            word_mem[slot_idx_reg] <= word_reg;
        end
        a_word_reg <= word_mem[cnt_reg];
    end

    // Decode: trailing ones give the size, start clears them
    always_comb begin
        w_ext     = {1'b0, a_word_reg};
        w_xor     = w_ext ^ (w_ext + (WORD_W + 1)'(1));
        low_mask  = w_xor[WORD_W:1];
        dec_start = {a_word_reg & ~low_mask, 2'b00};
        dec_end   = END_W'(dec_start) | {low_mask, 3'b111};
    end

    always_ff @(posedge aclk) begin
        b_idx_reg   <= a_idx_reg;
        b_on_reg    <= a_on_reg;
        b_start_reg <= dec_start;
        b_end_reg   <= dec_end;
    end

    // Compare stage: first hit and first free slot
    always_comb begin
        match     = (b_start_reg == base_reg);
        overlap   = !size_zero_reg
                 && (EXT_W'(base_reg) <= EXT_W'(b_end_reg))
                 && (EXT_W'(b_start_reg) <= nend_reg);
        entry_hit = b_on_reg && ((mode_reg == nrta_pkg::MODE_FREE) ? match : overlap);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= 1'b0;
            slot_reg <= 1'b0;
        end else if (cmd.prep) begin
            hit_reg  <= 1'b0;
            slot_reg <= 1'b0;
        end else if (b_vld_reg) begin
            if (entry_hit && !hit_reg) begin
                hit_reg <= 1'b1;
            end
            if (!b_on_reg && !slot_reg) begin
                slot_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_vld_reg && entry_hit && !hit_reg) begin
            hit_idx_reg <= b_idx_reg;
        end
        if (b_vld_reg && !b_on_reg && !slot_reg) begin
            slot_idx_reg <= b_idx_reg;
        end
    end

    // Final status
    always_comb begin
        index_calc = '0;
        priority if (!pma_supported) begin
            status_calc = nrta_pkg::STATUS_UNSUP;
        end else if (mode_reg == nrta_pkg::MODE_FREE) begin
            status_calc = hit_reg ? nrta_pkg::STATUS_OK : nrta_pkg::STATUS_FAIL;
            index_calc  = hit_reg ? hit_idx_reg : '0;
        end else if (hit_reg) begin
            status_calc = nrta_pkg::STATUS_OVERLAP;
        end else if (!slot_reg || bad_reg) begin
            status_calc = nrta_pkg::STATUS_FAIL;
        end else begin
            status_calc = nrta_pkg::STATUS_OK;
            index_calc  = slot_idx_reg;
        end
    end

    // Enable bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_reg <= '0;
        end else if (cmd.commit && (status_calc == nrta_pkg::STATUS_OK)) begin
            if (mode_reg == nrta_pkg::MODE_FREE) begin
                on_reg[hit_idx_reg] <= 1'b0;
            end else begin
                on_reg[slot_idx_reg] <= (type_reg != nrta_pkg::ETYP_OFF);
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg <= status_calc;
            index_reg  <= OIDX_W'(index_calc);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_index = index_reg;

endmodule

`default_nettype wire

### hdl/nrta_checker.sv
// ----------------------------------------------------------------------------
// nrta_checker
// Port-level checks for the region table allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nrta_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [nrta_pkg::STATUS_W-1:0]     m_status,
    input wire logic [nrta_pkg::OUT_IDX_W-1:0]    m_entry_index
);

    // After reset: no result pending, ready for a request
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("nrta: bad state after reset");

    // One request at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("nrta: request accepted while another is in flight");

    // A failed request reports entry zero
    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != nrta_pkg::STATUS_OK)) |-> (m_entry_index == '0))
        else $error("nrta: nonzero index on failed request");

    // Stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_status) && $stable(m_entry_index)))
        else $error("nrta: stalled result changed");

endmodule

bind napot_region_table_alloc_unit nrta_checker u_nrta_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_entry_index (m_entry_index)
);

`default_nettype wire
